### src/twpsm_pkg.sv
// Package with shared types and constants for the three-wire panel serial master.
`timescale 1ns / 1ps
`default_nettype none
package twpsm_pkg;

    localparam int DEF_WORD_BITS      = 16;
    localparam int DEF_READ_ADDR_BITS = 5;
    localparam int DEF_READ_DATA_BITS = 11;

    localparam int TICK_W  = 16;
    localparam int CMD_W   = 16;
    localparam int RVAL_W  = 11;

    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_END_HOLD    = 1'b1;

    localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 16'd20;
    localparam logic [TICK_W-1:0] END_HOLD_RESET    = 16'd20;

    typedef struct packed {
        logic              start_req;
        logic              kind;
        logic [CMD_W-1:0]  command;
        logic              sdi;
    } t_in_req;

    typedef struct packed {
        logic              sclk;
        logic              sdo;
        logic              sdo_enable;
        logic              csn;
        logic              busy_res;
        logic              done_res;
        logic [RVAL_W-1:0] read_value;
    } t_out_res;

    typedef struct packed {
        logic [TICK_W-1:0] half_period_ticks;
        logic [TICK_W-1:0] end_hold_ticks;
    } t_cfg;

endpackage
`default_nettype wire

### src/twpsm_core.sv
// Per-tick state update of the serial master: phase sequencer, shifters and pin levels.
`timescale 1ns / 1ps
`default_nettype none
module twpsm_core
    import twpsm_pkg::*;
#(
    parameter int WORD_BITS      = DEF_WORD_BITS,
    parameter int READ_ADDR_BITS = DEF_READ_ADDR_BITS,
    parameter int READ_DATA_BITS = DEF_READ_DATA_BITS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_req  i_req,
    input  wire t_cfg     i_cfg,
    output t_out_res      o_res
);

    localparam int TOTAL_MAX = (WORD_BITS > READ_ADDR_BITS + READ_DATA_BITS) ?
                               WORD_BITS : READ_ADDR_BITS + READ_DATA_BITS;
    localparam int BIT_W = $clog2(TOTAL_MAX);
    localparam int CNT_W = BIT_W + 1;
    localparam int FLAG_POS = (READ_ADDR_BITS < WORD_BITS) ? WORD_BITS - READ_ADDR_BITS : 0;
    localparam logic [WORD_BITS-1:0] READ_FLAG = (READ_ADDR_BITS < WORD_BITS) ?
                               (WORD_BITS'(1) << FLAG_POS) : '0;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SETUP = 3'd1;
    localparam logic [2:0] PH_LOW   = 3'd2;
    localparam logic [2:0] PH_HIGH  = 3'd3;
    localparam logic [2:0] PH_HOLD  = 3'd4;

    logic [2:0]                r_phase, n_phase;
    logic [TICK_W-1:0]         r_tick, n_tick;
    logic [BIT_W-1:0]          r_bit, n_bit;
    logic [WORD_BITS-1:0]      r_out_shift, n_out_shift;
    logic [READ_DATA_BITS-1:0] r_in_shift, n_in_shift;
    logic                      r_read_mode, n_read_mode;
    logic                      r_clk_lvl, n_clk_lvl;
    logic                      r_data_lvl, n_data_lvl;
    logic                      r_sel_lvl, n_sel_lvl;

    logic [TICK_W-1:0]  w_half_lim, w_hold_lim;
    logic [TICK_W:0]    w_tick_inc;
    logic               w_half_end, w_hold_end;
    logic [CNT_W-1:0]   w_bit_ext, w_bit_inc, w_total;
    logic               w_addr_part;
    logic [READ_DATA_BITS+RVAL_W-1:0] w_in_wide;
    logic [WORD_BITS+CMD_W-1:0]       w_cmd_wide;
    logic               w_done;
    logic [RVAL_W-1:0]  w_rv;
    logic               w_enable;

    assign w_half_lim = (i_cfg.half_period_ticks == '0) ? TICK_W'(1) : i_cfg.half_period_ticks;
    assign w_hold_lim = (i_cfg.end_hold_ticks == '0) ? TICK_W'(1) : i_cfg.end_hold_ticks;
    assign w_tick_inc = {1'b0, r_tick} + (TICK_W + 1)'(1);
    assign w_half_end = w_tick_inc >= {1'b0, w_half_lim};
    assign w_hold_end = w_tick_inc >= {1'b0, w_hold_lim};
    assign w_bit_ext  = {1'b0, r_bit};
    assign w_bit_inc  = w_bit_ext + CNT_W'(1);
    assign w_total    = r_read_mode ? CNT_W'(READ_ADDR_BITS + READ_DATA_BITS) : CNT_W'(WORD_BITS);
    assign w_addr_part = w_bit_ext < CNT_W'(READ_ADDR_BITS);
    assign w_in_wide  = (READ_DATA_BITS + RVAL_W)'(r_in_shift);
    assign w_cmd_wide = (WORD_BITS + CMD_W)'(i_req.command);

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_read_mode = r_read_mode;
        n_clk_lvl   = r_clk_lvl;
        n_data_lvl  = r_data_lvl;
        n_sel_lvl   = r_sel_lvl;
        w_done      = 1'b0;
        w_rv        = '0;
        unique case (r_phase)
            PH_SETUP: begin
                if (w_half_end) begin
                    n_tick    = '0;
                    n_phase   = PH_LOW;
                    n_clk_lvl = 1'b0;
                end else begin
                    n_tick = w_tick_inc[TICK_W-1:0];
                end
            end
            PH_LOW: begin
                if (w_half_end) begin
                    n_tick = '0;
                    if (!r_read_mode || w_addr_part) begin
                        n_data_lvl  = r_out_shift[WORD_BITS-1];
                        n_out_shift = r_out_shift << 1;
                    end else begin
                        n_in_shift = (r_in_shift << 1) | READ_DATA_BITS'(i_req.sdi);
                    end
                    n_phase   = PH_HIGH;
                    n_clk_lvl = 1'b1;
                end else begin
                    n_tick = w_tick_inc[TICK_W-1:0];
                end
            end
            PH_HIGH: begin
                if (w_half_end) begin
                    n_tick = '0;
                    if (w_bit_inc >= w_total) begin
                        n_phase   = PH_HOLD;
                        n_sel_lvl = 1'b1;
                        w_done    = 1'b1;
                        w_rv      = r_read_mode ? w_in_wide[RVAL_W-1:0] : '0;
                    end else begin
                        n_bit     = w_bit_inc[BIT_W-1:0];
                        n_phase   = PH_LOW;
                        n_clk_lvl = 1'b0;
                    end
                end else begin
                    n_tick = w_tick_inc[TICK_W-1:0];
                end
            end
            PH_HOLD: begin
                if (w_hold_end) begin
                    n_tick  = '0;
                    n_phase = PH_IDLE;
                end else begin
                    n_tick = w_tick_inc[TICK_W-1:0];
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_req.start_req) begin
                    n_read_mode = i_req.kind;
                    n_out_shift = w_cmd_wide[WORD_BITS-1:0] | (i_req.kind ? READ_FLAG : '0);
                    n_in_shift  = '0;
                    n_bit       = '0;
                    n_tick      = '0;
                    n_clk_lvl   = 1'b1;
                    n_sel_lvl   = 1'b0;
                    n_phase     = PH_SETUP;
                end
            end
        endcase
    end

    assign w_enable = !(n_read_mode && ({1'b0, n_bit} >= CNT_W'(READ_ADDR_BITS)) &&
                        (n_phase == PH_LOW || n_phase == PH_HIGH || n_phase == PH_HOLD));

    always_comb begin
        o_res.sclk       = n_clk_lvl;
        o_res.sdo        = w_enable & n_data_lvl;
        o_res.sdo_enable = w_enable;
        o_res.csn        = n_sel_lvl;
        o_res.busy_res   = n_phase != PH_IDLE;
        o_res.done_res   = w_done;
        o_res.read_value = w_rv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_out_shift <= '0;
            r_in_shift  <= '0;
            r_read_mode <= 1'b0;
            r_clk_lvl   <= 1'b1;
            r_data_lvl  <= 1'b0;
            r_sel_lvl   <= 1'b1;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_out_shift <= n_out_shift;
            r_in_shift  <= n_in_shift;
            r_read_mode <= n_read_mode;
            r_clk_lvl   <= n_clk_lvl;
            r_data_lvl  <= n_data_lvl;
            r_sel_lvl   <= n_sel_lvl;
        end
    end

endmodule
`default_nettype wire

### src/three_wire_panel_serial_master.sv
// Top level of the three-wire panel serial master with configuration and result register.
// Each request is one clock tick of the serial master, and a new request is taken in every
// cycle, also while the previous result waits, as long as the result register is free or
// being read in that cycle. The response to a request is held in the result register
// and appears in the cycle after acceptance. Pin timing is set by the half period and
// end hold registers, counted in requests; a value of zero acts as one. A write frame
// covers one setup half period, two half periods per bit and the end hold; a read frame
// sends the address bits and then samples the data bits on the last low tick of each bit.
`timescale 1ns / 1ps
`default_nettype none
module three_wire_panel_serial_master
    import twpsm_pkg::*;
#(
    parameter int WORD_BITS      = DEF_WORD_BITS,
    parameter int READ_ADDR_BITS = DEF_READ_ADDR_BITS,
    parameter int READ_DATA_BITS = DEF_READ_DATA_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_req           i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_res               o_out,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [TICK_W-1:0] i_cfg_data
);

    logic     w_accept;
    t_cfg     r_cfg;
    t_out_res w_res;
    t_out_res r_out;
    logic     r_out_valid;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_PERIOD_RESET;
            r_cfg.end_hold_ticks    <= END_HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data;
                CFG_END_HOLD:    r_cfg.end_hold_ticks    <= i_cfg_data;
                default:         r_cfg                   <= r_cfg;
            endcase
        end
    end

    twpsm_core #(
        .WORD_BITS      (WORD_BITS),
        .READ_ADDR_BITS (READ_ADDR_BITS),
        .READ_DATA_BITS (READ_DATA_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_accept),
        .i_req   (i_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

### src/twpsm_checker.sv
// Port-level checker for the three-wire panel serial master and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module twpsm_checker
    import twpsm_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_out_res o_out
);

    a_done_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.done_res |-> o_out.csn && o_out.sclk && o_out.busy_res)
        else $error("done without chip select high and clock high");

    a_released_pin_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.sdo_enable |-> !o_out.sdo && o_out.busy_res)
        else $error("released data pin driven or released while idle");

    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.busy_res |-> o_out.csn && o_out.sclk && o_out.sdo_enable)
        else $error("idle pins not at rest levels");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

bind three_wire_panel_serial_master twpsm_checker u_twpsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire
